@@ src/dps_pkg.sv @@
`default_nettype none

package dps_pkg;

	// gain scaling, fraction bits of the three gains
	localparam int GAIN_FRAC_BITS = 40;

	localparam int WORD_W   = 32;
	localparam int GAIN_W   = 48;
	localparam int GAIN_HW  = GAIN_W / 2;
	localparam int ERR_W    = 40;
	localparam int DER_W    = ERR_W + 1;
	localparam int SUM_W    = 48;
	localparam int DRV_W    = 16;
	localparam int PROD_W   = 62;
	localparam int PP_W     = SUM_W + GAIN_HW + 1;
	localparam int ACC_W    = 98;
	localparam int MODES    = 4;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = GAIN_W;

	// 360 / (2.75 * pi) in Q24
	localparam logic [29:0] DIST_SCALE_Q24 = 30'd699100850;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = 48'd19791209300;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 48'd2199023;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 48'd104453604639;
	localparam logic [30:0]       ERR_LIMIT_RST = 31'd51200;
	localparam logic [14:0]       SPEED_LIMIT_RST = 15'd512;
	localparam logic [14:0]       CEILING_RST = 15'd2560;

	typedef enum logic [1:0] {
		MODE_FWD,
		MODE_REV,
		MODE_LEFT,
		MODE_RIGHT
	} mode_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MODE,
		CFG_TARGET,
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D,
		CFG_ERR_LIMIT,
		CFG_SPEED_LIMIT,
		CFG_CEILING
	} cfg_idx_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [WORD_W-1:0] target;
		logic [GAIN_W-1:0]        gain_p;
		logic [GAIN_W-1:0]        gain_i;
		logic [GAIN_W-1:0]        gain_d;
		logic [30:0]              error_limit;
		logic [14:0]              speed_limit;
		logic [14:0]              drive_ceiling;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] last_error;
		logic signed [SUM_W-1:0] error_sum;
	} entry_t;

	typedef enum logic [2:0] {
		CORE_IDLE,
		CORE_LOAD,
		CORE_MUL,
		CORE_ACC,
		CORE_SAT,
		CORE_OUT
	} core_state_t;

endpackage

`default_nettype wire

@@ src/dps_ram.sv @@
`default_nettype none

module dps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/dps_err.sv @@
`default_nettype none

module dps_err (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire dps_pkg::cfg_t                          cfg,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [dps_pkg::WORD_W-1:0]      right_wheel,
	input  wire logic signed [dps_pkg::WORD_W-1:0]      left_wheel,
	input  wire logic signed [dps_pkg::WORD_W-1:0]      heading,
	output logic                                        err_valid,
	input  wire logic                                   err_ready,
	output logic signed [dps_pkg::ERR_W-1:0]            err
);

	logic s1_vld_q, s2_vld_q, s3_vld_q;
	logic s1_en, s2_en, s3_en;

	logic signed [dps_pkg::WORD_W-1:0] r_s1, l_s1, h_s1;
	logic [dps_pkg::PROD_W-1:0]        prod_s2;
	logic signed [dps_pkg::WORD_W:0]   pos_s2;
	logic [dps_pkg::WORD_W:0]          hmag_s2;
	logic signed [dps_pkg::ERR_W-1:0]  err_s3;

	logic [dps_pkg::WORD_W-1:0]        tmag;
	logic [dps_pkg::PROD_W-1:0]        prod_d;
	logic signed [dps_pkg::WORD_W:0]   pos_d;
	logic [dps_pkg::WORD_W:0]          hx, hmag_d;

	logic [dps_pkg::PROD_W-1:0]        rnd;
	logic [37:0]                       conv_mag;
	logic signed [dps_pkg::ERR_W-1:0]  conv;
	logic signed [dps_pkg::WORD_W+1:0] pos34, pmag;
	logic signed [dps_pkg::WORD_W:0]   half;
	logic signed [dps_pkg::ERR_W-1:0]  err_d;

	assign s3_en    = !s3_vld_q || err_ready;
	assign s2_en    = !s2_vld_q || s3_en;
	assign s1_en    = !s1_vld_q || s2_en;
	assign in_ready = s1_en;

	assign err_valid = s3_vld_q;
	assign err       = err_s3;

	// magnitudes and the distance scaling product
	assign tmag   = cfg.target[dps_pkg::WORD_W-1] ? (~cfg.target + 32'sd1) : cfg.target;
	assign prod_d = {30'd0, tmag} * {32'd0, dps_pkg::DIST_SCALE_Q24};
	assign pos_d  = {r_s1[dps_pkg::WORD_W-1], r_s1} + {l_s1[dps_pkg::WORD_W-1], l_s1};
	assign hx     = {h_s1[dps_pkg::WORD_W-1], h_s1};
	assign hmag_d = h_s1[dps_pkg::WORD_W-1] ? (~hx + 33'd1) : hx;

	// error per mode
	always_comb begin
		rnd      = prod_s2 + 62'd8388608;
		conv_mag = rnd[dps_pkg::PROD_W-1:24];
		conv     = cfg.target[dps_pkg::WORD_W-1] ? -$signed({2'b00, conv_mag})
			: $signed({2'b00, conv_mag});
		// halving truncates toward zero
		pos34 = {pos_s2[dps_pkg::WORD_W], pos_s2} + {33'd0, pos_s2[dps_pkg::WORD_W]};
		pmag  = pos_s2[dps_pkg::WORD_W] ? -{pos_s2[dps_pkg::WORD_W], pos_s2}
			: {pos_s2[dps_pkg::WORD_W], pos_s2};
		if (cfg.mode == dps_pkg::MODE_REV) begin
			half = pmag[dps_pkg::WORD_W+1:1];
		end else begin
			half = pos34[dps_pkg::WORD_W+1:1];
		end
		if (cfg.mode inside {dps_pkg::MODE_LEFT, dps_pkg::MODE_RIGHT}) begin
			err_d = $signed({8'd0, tmag}) - $signed({7'd0, hmag_s2});
		end else begin
			err_d = conv - {{7{half[dps_pkg::WORD_W]}}, half};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
			s3_vld_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_vld_q <= in_valid;
			end
			if (s2_en) begin
				s2_vld_q <= s1_vld_q;
			end
			if (s3_en) begin
				s3_vld_q <= s2_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && in_valid) begin
			r_s1 <= right_wheel;
			l_s1 <= left_wheel;
			h_s1 <= heading;
		end
		if (s2_en && s1_vld_q) begin
			prod_s2 <= prod_d;
			pos_s2  <= pos_d;
			hmag_s2 <= hmag_d;
		end
		if (s3_en && s2_vld_q) begin
			err_s3 <= err_d;
		end
	end

endmodule

`default_nettype wire

@@ src/dps_core.sv @@
`default_nettype none

module dps_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dps_pkg::cfg_t                      cfg,
	input  wire logic                               err_valid,
	output logic                                    err_ready,
	input  wire logic signed [dps_pkg::ERR_W-1:0]   err,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [dps_pkg::DRV_W-1:0]        right_drive,
	output logic signed [dps_pkg::DRV_W-1:0]        left_drive,
	output logic                                    brake,
	output logic signed [dps_pkg::WORD_W-1:0]       error_now
);

	localparam int ENTRY_W = $bits(dps_pkg::entry_t);

	dps_pkg::core_state_t state_q, state_d;

	logic [2:0]                          cnt_q;
	logic signed [dps_pkg::ERR_W-1:0]    err_q, last_q;
	logic signed [dps_pkg::DER_W-1:0]    deriv_q;
	logic signed [dps_pkg::SUM_W-1:0]    sum_q;
	logic signed [dps_pkg::PP_W-1:0]     pp_q;
	logic                                pp_hi_q, pp_vld_q;
	logic signed [dps_pkg::ACC_W-1:0]    acc_q;
	logic signed [dps_pkg::DRV_W-1:0]    drive_q;
	logic                                fwd_q;
	dps_pkg::entry_t                     fwd_data_q;
	logic [dps_pkg::MODES-1:0]           vld_q;
	logic                                out_valid_q;

	logic                                out_go, rd_en, wr_en;
	logic [ENTRY_W-1:0]                  rdata;
	dps_pkg::entry_t                     ent, wdata;
	logic signed [dps_pkg::DER_W-1:0]    deriv_d;
	logic signed [dps_pkg::SUM_W:0]      s49;
	logic signed [dps_pkg::SUM_W-1:0]    sum_d;
	logic signed [dps_pkg::SUM_W-1:0]    op_a;
	logic [dps_pkg::GAIN_W-1:0]          gain;
	logic [dps_pkg::GAIN_HW-1:0]         op_b;
	logic signed [dps_pkg::PP_W-1:0]     pp_d;
	logic signed [dps_pkg::ACC_W-1:0]    pp_ext;
	logic signed [dps_pkg::ACC_W-1:0]    sh;
	logic signed [dps_pkg::DRV_W-1:0]    sat_d, drive_d, neg_d, rd_d, ld_d;
	logic                                brake_d;
	logic signed [dps_pkg::WORD_W-1:0]   enow_d;

	assign out_go    = !out_valid_q || out_ready;
	assign err_ready = (state_q == dps_pkg::CORE_IDLE)
		|| (state_q == dps_pkg::CORE_OUT && out_go);
	assign rd_en     = err_valid && err_ready;
	assign wr_en     = (state_q == dps_pkg::CORE_OUT) && out_go;
	assign out_valid = out_valid_q;

	dps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(dps_pkg::MODES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cfg.mode),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(cfg.mode),
		.rdata(rdata)
	);

	// state entry: forwarded write, stored word, or zero if never written
	always_comb begin
		if (fwd_q) begin
			ent = fwd_data_q;
		end else if (vld_q[cfg.mode]) begin
			ent = dps_pkg::entry_t'(rdata);
		end else begin
			ent = '0;
		end
		deriv_d = {err_q[dps_pkg::ERR_W-1], err_q}
			- {ent.last_error[dps_pkg::ERR_W-1], ent.last_error};
		s49 = {ent.error_sum[dps_pkg::SUM_W-1], ent.error_sum}
			+ {{(dps_pkg::SUM_W-dps_pkg::ERR_W+1){err_q[dps_pkg::ERR_W-1]}}, err_q};
		if (s49[dps_pkg::SUM_W] != s49[dps_pkg::SUM_W-1]) begin
			sum_d = s49[dps_pkg::SUM_W] ? {1'b1, {(dps_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(dps_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_d = s49[dps_pkg::SUM_W-1:0];
		end
	end

	// one signed 48 x unsigned 24 product per cycle
	always_comb begin
		case (cnt_q)
			3'd0, 3'd1: begin
				op_a = {{(dps_pkg::SUM_W-dps_pkg::ERR_W){err_q[dps_pkg::ERR_W-1]}}, err_q};
				gain = cfg.gain_p;
			end
			3'd2, 3'd3: begin
				op_a = {{(dps_pkg::SUM_W-dps_pkg::DER_W){deriv_q[dps_pkg::DER_W-1]}}, deriv_q};
				gain = cfg.gain_d;
			end
			default: begin
				op_a = sum_q;
				gain = cfg.gain_i;
			end
		endcase
		op_b   = cnt_q[0] ? gain[dps_pkg::GAIN_W-1:dps_pkg::GAIN_HW]
			: gain[dps_pkg::GAIN_HW-1:0];
		pp_d   = op_a * $signed({1'b0, op_b});
		pp_ext = {{(dps_pkg::ACC_W-dps_pkg::PP_W){pp_q[dps_pkg::PP_W-1]}}, pp_q};
	end

	// scale, saturate, cap in the turn modes
	always_comb begin
		sh = acc_q >>> dps_pkg::GAIN_FRAC_BITS;
		if ((&sh[dps_pkg::ACC_W-1:dps_pkg::DRV_W-1]) || !(|sh[dps_pkg::ACC_W-1:dps_pkg::DRV_W-1]))
		begin
			sat_d = sh[dps_pkg::DRV_W-1:0];
		end else if (sh[dps_pkg::ACC_W-1]) begin
			sat_d = {1'b1, {(dps_pkg::DRV_W-1){1'b0}}};
		end else begin
			sat_d = {1'b0, {(dps_pkg::DRV_W-1){1'b1}}};
		end
		drive_d = sat_d;
		if ((cfg.mode inside {dps_pkg::MODE_LEFT, dps_pkg::MODE_RIGHT})
			&& (sat_d > $signed({1'b0, cfg.drive_ceiling}))) begin
			drive_d = $signed({1'b0, cfg.drive_ceiling});
		end
	end

	// finish flag, motor sides, reported error
	always_comb begin
		brake_d = (err_q < $signed({9'd0, cfg.error_limit}))
			&& (drive_q < $signed({1'b0, cfg.speed_limit}));
		neg_d = (drive_q == {1'b1, {(dps_pkg::DRV_W-1){1'b0}}})
			? {1'b0, {(dps_pkg::DRV_W-1){1'b1}}} : -drive_q;
		case (cfg.mode)
			dps_pkg::MODE_FWD: begin
				rd_d = drive_q;
				ld_d = drive_q;
			end
			dps_pkg::MODE_REV: begin
				rd_d = neg_d;
				ld_d = neg_d;
			end
			dps_pkg::MODE_LEFT: begin
				rd_d = drive_q;
				ld_d = neg_d;
			end
			default: begin
				rd_d = neg_d;
				ld_d = drive_q;
			end
		endcase
		if ((&err_q[dps_pkg::ERR_W-1:dps_pkg::WORD_W-1])
			|| !(|err_q[dps_pkg::ERR_W-1:dps_pkg::WORD_W-1])) begin
			enow_d = err_q[dps_pkg::WORD_W-1:0];
		end else if (err_q[dps_pkg::ERR_W-1]) begin
			enow_d = {1'b1, {(dps_pkg::WORD_W-1){1'b0}}};
		end else begin
			enow_d = {1'b0, {(dps_pkg::WORD_W-1){1'b1}}};
		end
		wdata.last_error = brake_d ? last_q : err_q;
		wdata.error_sum  = sum_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dps_pkg::CORE_IDLE: begin
				if (rd_en) begin
					state_d = dps_pkg::CORE_LOAD;
				end
			end
			dps_pkg::CORE_LOAD: begin
				state_d = dps_pkg::CORE_MUL;
			end
			dps_pkg::CORE_MUL: begin
				if (cnt_q == 3'd5) begin
					state_d = dps_pkg::CORE_ACC;
				end
			end
			dps_pkg::CORE_ACC: begin
				state_d = dps_pkg::CORE_SAT;
			end
			dps_pkg::CORE_SAT: begin
				state_d = dps_pkg::CORE_OUT;
			end
			dps_pkg::CORE_OUT: begin
				if (out_go) begin
					state_d = rd_en ? dps_pkg::CORE_LOAD : dps_pkg::CORE_IDLE;
				end
			end
			default: begin
				state_d = dps_pkg::CORE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dps_pkg::CORE_IDLE;
			cnt_q       <= 3'd0;
			pp_vld_q    <= 1'b0;
			fwd_q       <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pp_vld_q <= (state_q == dps_pkg::CORE_MUL);
			if (state_q == dps_pkg::CORE_MUL) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= 3'd0;
			end
			if (rd_en) begin
				fwd_q <= (state_q == dps_pkg::CORE_OUT);
			end
			if (wr_en) begin
				vld_q[cfg.mode] <= 1'b1;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			err_q <= err;
		end
		if (state_q == dps_pkg::CORE_LOAD) begin
			last_q  <= ent.last_error;
			deriv_q <= deriv_d;
			sum_q   <= sum_d;
			acc_q   <= '0;
		end else if (pp_vld_q) begin
			acc_q <= acc_q + (pp_hi_q ? (pp_ext <<< dps_pkg::GAIN_HW) : pp_ext);
		end
		if (state_q == dps_pkg::CORE_MUL) begin
			pp_q    <= pp_d;
			pp_hi_q <= cnt_q[0];
		end
		if (state_q == dps_pkg::CORE_SAT) begin
			drive_q <= drive_d;
		end
		if (wr_en) begin
			fwd_data_q  <= wdata;
			right_drive <= rd_d;
			left_drive  <= ld_d;
			brake       <= brake_d;
			error_now   <= enow_d;
		end
	end

endmodule

`default_nettype wire

@@ src/drive_pid_step.sv @@
// channel   direction  handshake              word
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    right_wheel, left_wheel, heading
// out       out        out_valid / out_ready  right_drive, left_drive, brake, error_now
//
// an item passes through the error pipe, then through the core:
// state read, six passes of one 48x24 multiplier, accumulate, scale, write-back
// the core takes a new word no earlier than the write-back of the last, as the
// per-mode state read-modify-write works around the shared multiplier
// after reset all four mode entries read as zero through per-entry valid flags
// a full output register stalls the core; the error pipe keeps accepting
// until its three stages fill
`default_nettype none

module drive_pid_step (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration writes
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [dps_pkg::CFG_AW-1:0]             cfg_index,
	input  wire logic [dps_pkg::CFG_DW-1:0]             cfg_data,
	// sensor tick
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [dps_pkg::WORD_W-1:0]      right_wheel,
	input  wire logic signed [dps_pkg::WORD_W-1:0]      left_wheel,
	input  wire logic signed [dps_pkg::WORD_W-1:0]      heading,
	// motor command
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [dps_pkg::DRV_W-1:0]            right_drive,
	output logic signed [dps_pkg::DRV_W-1:0]            left_drive,
	output logic                                        brake,
	output logic signed [dps_pkg::WORD_W-1:0]           error_now
);

	dps_pkg::cfg_t cfg_q;

	logic                               err_valid, err_ready;
	logic signed [dps_pkg::ERR_W-1:0]   err;

	// register file is always writable; the host must write only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= dps_pkg::MODE_FWD;
			cfg_q.target        <= '0;
			cfg_q.gain_p        <= dps_pkg::GAIN_P_RST;
			cfg_q.gain_i        <= dps_pkg::GAIN_I_RST;
			cfg_q.gain_d        <= dps_pkg::GAIN_D_RST;
			cfg_q.error_limit   <= dps_pkg::ERR_LIMIT_RST;
			cfg_q.speed_limit   <= dps_pkg::SPEED_LIMIT_RST;
			cfg_q.drive_ceiling <= dps_pkg::CEILING_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (dps_pkg::cfg_idx_t'(cfg_index))
				dps_pkg::CFG_MODE: begin
					cfg_q.mode <= dps_pkg::mode_t'(cfg_data[1:0]);
				end
				dps_pkg::CFG_TARGET: begin
					cfg_q.target <= cfg_data[dps_pkg::WORD_W-1:0];
				end
				dps_pkg::CFG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data;
				end
				dps_pkg::CFG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data;
				end
				dps_pkg::CFG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data;
				end
				dps_pkg::CFG_ERR_LIMIT: begin
					cfg_q.error_limit <= cfg_data[30:0];
				end
				dps_pkg::CFG_SPEED_LIMIT: begin
					cfg_q.speed_limit <= cfg_data[14:0];
				end
				dps_pkg::CFG_CEILING: begin
					cfg_q.drive_ceiling <= cfg_data[14:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// error pipe: scaled setpoint minus position or heading
	dps_err u_err (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.right_wheel(right_wheel),
		.left_wheel (left_wheel),
		.heading    (heading),
		.err_valid  (err_valid),
		.err_ready  (err_ready),
		.err        (err)
	);

	// per-mode state RAM, gain products, output register
	dps_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.err_valid  (err_valid),
		.err_ready  (err_ready),
		.err        (err),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.right_drive(right_drive),
		.left_drive (left_drive),
		.brake      (brake),
		.error_now  (error_now)
	);

endmodule

`default_nettype wire

@@ tb/drive_cmd_pkg.sv @@
`timescale 1ns / 100ps

package drive_cmd_pkg;

	// one motor command word as it leaves the block
	typedef struct packed {
		logic signed [dps_pkg::DRV_W-1:0]  right_drive;
		logic signed [dps_pkg::DRV_W-1:0]  left_drive;
		logic                              brake;
		logic signed [dps_pkg::WORD_W-1:0] error_now;
	} motor_cmd_t;

	class motor_cmd_ledger;
		dps_pkg::cfg_t                      regs;
		logic signed [dps_pkg::ERR_W-1:0]   prev_err [dps_pkg::MODES];
		logic signed [dps_pkg::SUM_W-1:0]   err_acc [dps_pkg::MODES];
		motor_cmd_t                         pending_cmds [$];
		int                                 mismatches;

		function new();
			regs.mode          = dps_pkg::MODE_FWD;
			regs.target        = '0;
			regs.gain_p        = dps_pkg::GAIN_P_RST;
			regs.gain_i        = dps_pkg::GAIN_I_RST;
			regs.gain_d        = dps_pkg::GAIN_D_RST;
			regs.error_limit   = dps_pkg::ERR_LIMIT_RST;
			regs.speed_limit   = dps_pkg::SPEED_LIMIT_RST;
			regs.drive_ceiling = dps_pkg::CEILING_RST;
			for (int k = 0; k < dps_pkg::MODES; k++) begin
				prev_err[k] = '0;
				err_acc[k]  = '0;
			end
			mismatches = 0;
		endfunction

		function void set_reg(input dps_pkg::cfg_idx_t idx, input logic [dps_pkg::CFG_DW-1:0] d);
			case (idx)
				dps_pkg::CFG_MODE:        regs.mode = dps_pkg::mode_t'(d[1:0]);
				dps_pkg::CFG_TARGET:      regs.target = d[31:0];
				dps_pkg::CFG_GAIN_P:      regs.gain_p = d;
				dps_pkg::CFG_GAIN_I:      regs.gain_i = d;
				dps_pkg::CFG_GAIN_D:      regs.gain_d = d;
				dps_pkg::CFG_ERR_LIMIT:   regs.error_limit = d[30:0];
				dps_pkg::CFG_SPEED_LIMIT: regs.speed_limit = d[14:0];
				dps_pkg::CFG_CEILING:     regs.drive_ceiling = d[14:0];
				default: ;
			endcase
		endfunction

		// work out the command for one accepted sensor word and queue it
		function void predict_tick(input logic signed [31:0] r, input logic signed [31:0] l,
				input logic signed [31:0] h);
			dps_pkg::mode_t      m;
			logic signed [31:0]  tgt;
			longint              t64, t_mag, conv, pos, h_mag, err, deriv, sum;
			longint              drive, inv, rd, ld, enow, err_lim, spd_lim, ceil;
			longint unsigned     prod;
			logic signed [127:0] e_w, d_w, s_w, gp_w, gi_w, gd_w, acc;
			logic                brk;
			motor_cmd_t          cmd;

			m       = regs.mode;
			tgt     = regs.target;
			t64     = tgt;
			t_mag   = (t64 < 0) ? -t64 : t64;
			err_lim = regs.error_limit;
			spd_lim = regs.speed_limit;
			ceil    = regs.drive_ceiling;

			if (m == dps_pkg::MODE_FWD || m == dps_pkg::MODE_REV) begin
				// inches to wheel degrees, round half away from zero
				prod = t_mag;
				prod = prod * dps_pkg::DIST_SCALE_Q24;
				conv = (prod + (64'd1 << 23)) >> 24;
				if (t64 < 0)
					conv = -conv;
				pos = longint'(r) + longint'(l);
				if (m == dps_pkg::MODE_REV && pos < 0)
					pos = -pos;
				err = conv - pos / 2;
			end else begin
				h_mag = h;
				if (h_mag < 0)
					h_mag = -h_mag;
				err = t_mag - h_mag;
			end

			deriv = err - longint'(prev_err[m]);
			sum   = longint'(err_acc[m]) + err;
			if (sum > 64'sh00007fffffffffff)
				sum = 64'sh00007fffffffffff;
			if (sum < -64'sh0000800000000000)
				sum = -64'sh0000800000000000;
			err_acc[m] = sum;

			e_w  = err;
			d_w  = deriv;
			s_w  = sum;
			gp_w = {80'd0, regs.gain_p};
			gi_w = {80'd0, regs.gain_i};
			gd_w = {80'd0, regs.gain_d};
			acc  = e_w * gp_w + d_w * gd_w + s_w * gi_w;
			acc  = acc >>> dps_pkg::GAIN_FRAC_BITS;
			if (acc > 32767)
				drive = 32767;
			else if (acc < -32768)
				drive = -32768;
			else
				drive = acc[63:0];
			if ((m == dps_pkg::MODE_LEFT || m == dps_pkg::MODE_RIGHT) && drive > ceil)
				drive = ceil;

			brk = (err < err_lim) && (drive < spd_lim);
			if (!brk)
				prev_err[m] = err;

			inv = (drive == -32768) ? 32767 : -drive;
			case (m)
				dps_pkg::MODE_FWD:  begin rd = drive; ld = drive; end
				dps_pkg::MODE_REV:  begin rd = inv;   ld = inv;   end
				dps_pkg::MODE_LEFT: begin rd = drive; ld = inv;   end
				default:            begin rd = inv;   ld = drive; end
			endcase

			enow = err;
			if (enow > 64'sh7fffffff)
				enow = 64'sh7fffffff;
			if (enow < -64'sh80000000)
				enow = -64'sh80000000;

			cmd.right_drive = rd[15:0];
			cmd.left_drive  = ld[15:0];
			cmd.brake       = brk;
			cmd.error_now   = enow[31:0];
			pending_cmds.push_back(cmd);
		endfunction

		function void check_cmd(input logic signed [15:0] rd, input logic signed [15:0] ld,
				input logic br, input logic signed [31:0] en);
			motor_cmd_t want;

			if (pending_cmds.size() == 0) begin
				$error("command word with nothing pending");
				mismatches++;
				return;
			end
			want = pending_cmds.pop_front();
			if (rd !== want.right_drive) begin
				$error("right_drive expected %0d actual %0d", want.right_drive, rd);
				mismatches++;
			end
			if (ld !== want.left_drive) begin
				$error("left_drive expected %0d actual %0d", want.left_drive, ld);
				mismatches++;
			end
			if (br !== want.brake) begin
				$error("brake expected %0d actual %0d", want.brake, br);
				mismatches++;
			end
			if (en !== want.error_now) begin
				$error("error_now expected %0d actual %0d", want.error_now, en);
				mismatches++;
			end
		endfunction
	endclass

endpackage

@@ tb/drive_pid_step_test.sv @@
`timescale 1ns / 100ps

module drive_pid_step_test;
	import dps_pkg::*;
	import drive_cmd_pkg::*;

	// no-progress cycles before giving up
	localparam int STALL_LIMIT = 2000;
	// quiet cycles after the last command, covers the core write-back
	localparam int SETTLE_CYCLES = 20;
	localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_AW-1:0]        cfg_index = '0;
	logic [CFG_DW-1:0]        cfg_data = '0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [WORD_W-1:0] right_wheel = '0;
	logic signed [WORD_W-1:0] left_wheel = '0;
	logic signed [WORD_W-1:0] heading = '0;

	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DRV_W-1:0]  right_drive;
	logic signed [DRV_W-1:0]  left_drive;
	logic                     brake;
	logic signed [WORD_W-1:0] error_now;

	// idle odds in percent per cycle for each side
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int stall_cycles = 0;

	motor_cmd_ledger ledger;
	cfg_t            cur;

	drive_pid_step i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.right_wheel (right_wheel),
		.left_wheel  (left_wheel),
		.heading     (heading),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.right_drive (right_drive),
		.left_drive  (left_drive),
		.brake       (brake),
		.error_now   (error_now)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// command side: check each accepted word, then pick next ready at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_cmd(right_drive, left_drive, brake, error_now);
		out_ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// watchdog on cycles where no channel moves a word
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// power-on register values
	function automatic cfg_t default_cfg();
		cfg_t c;
		c.mode          = MODE_FWD;
		c.target        = '0;
		c.gain_p        = GAIN_P_RST;
		c.gain_i        = GAIN_I_RST;
		c.gain_d        = GAIN_D_RST;
		c.error_limit   = ERR_LIMIT_RST;
		c.speed_limit   = SPEED_LIMIT_RST;
		c.drive_ceiling = CEILING_RST;
		return c;
	endfunction

	// mostly the tuned gain, sometimes any value or an extreme
	function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] rst);
		int k;
		k = $urandom_range(99);
		if (k < 60)
			return rst;
		else if (k < 85)
			return GAIN_W'({$urandom, $urandom});
		else if (k < 92)
			return '0;
		else
			return '1;
	endfunction

	function automatic logic [30:0] pick_limit(input logic [30:0] rst, input int bits);
		int k;
		logic [30:0] mask;
		k    = $urandom_range(99);
		mask = (31'd1 << bits) - 31'd1;
		if (k < 60)
			return rst;
		else if (k < 80)
			return 31'($urandom) & mask;
		else if (k < 90)
			return '0;
		else
			return mask;
	endfunction

	// sensor word, with a random gap in front of it
	task automatic send_tick(input logic signed [31:0] r, input logic signed [31:0] l,
			input logic signed [31:0] h);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct)
				@(posedge clk);
		end
		in_valid    <= 1'b1;
		right_wheel <= r;
		left_wheel  <= l;
		heading     <= h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ledger.predict_tick(r, l, h);
	endtask

	// stop sending and let every pending command come back
	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// valid stays up across back-to-back writes, caller lowers it
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		ledger.set_reg(idx, data);
	endtask

	// full register set, only once the block has gone quiet
	task automatic load_config(input cfg_t c);
		drain();
		write_reg(CFG_MODE, {46'd0, c.mode});
		write_reg(CFG_TARGET, {16'd0, c.target});
		write_reg(CFG_GAIN_P, c.gain_p);
		write_reg(CFG_GAIN_I, c.gain_i);
		write_reg(CFG_GAIN_D, c.gain_d);
		write_reg(CFG_ERR_LIMIT, {17'd0, c.error_limit});
		write_reg(CFG_SPEED_LIMIT, {33'd0, c.speed_limit});
		write_reg(CFG_CEILING, {33'd0, c.drive_ceiling});
		cfg_valid <= 1'b0;
	endtask

	// random moves: mostly a ramp toward the setpoint that settles and brakes,
	// some with any setpoint and random words, and stray words within ramps
	task automatic random_moves(input int quota);
		int     done, n, style, sgn, hsgn;
		longint t, goal, p, r, l, h;

		done = 0;
		while (done < quota) begin
			cur.mode = mode_t'($urandom_range(3));
			style    = $urandom_range(99);
			sgn      = $urandom_range(1) ? 1 : -1;
			hsgn     = $urandom_range(1) ? 1 : -1;
			if (style < 80)
				cur.target = sgn * int'($urandom_range(24576));
			else
				cur.target = $urandom;
			cur.gain_p        = pick_gain(GAIN_P_RST);
			cur.gain_i        = pick_gain(GAIN_I_RST);
			cur.gain_d        = pick_gain(GAIN_D_RST);
			cur.error_limit   = pick_limit(ERR_LIMIT_RST, 31);
			cur.speed_limit   = 15'(pick_limit({16'd0, SPEED_LIMIT_RST}, 15));
			cur.drive_ceiling = 15'(pick_limit({16'd0, CEILING_RST}, 15));
			load_config(cur);

			t = $signed(cur.target);
			if (cur.mode == MODE_FWD || cur.mode == MODE_REV)
				goal = (t * longint'(DIST_SCALE_Q24)) / 16777216;
			else
				goal = (t < 0) ? -t : t;

			n = $urandom_range(12, 60);
			for (int i = 0; i < n; i++) begin
				// reach the goal after three quarters of the move, then hold
				p = goal * (i + 1) * 4 / (n * 3);
				if ((goal >= 0 && p > goal) || (goal < 0 && p < goal))
					p = goal;
				case (cur.mode)
					MODE_FWD: begin
						r = p + int'($urandom_range(64)) - 32;
						l = p + int'($urandom_range(64)) - 32;
						h = int'($urandom_range(512)) - 256;
					end
					MODE_REV: begin
						r = -p + int'($urandom_range(64)) - 32;
						l = -p + int'($urandom_range(64)) - 32;
						h = int'($urandom_range(512)) - 256;
					end
					default: begin
						r = p + int'($urandom_range(64)) - 32;
						l = -p + int'($urandom_range(64)) - 32;
						h = hsgn * p + int'($urandom_range(32)) - 16;
					end
				endcase
				if (style >= 80 || $urandom_range(99) < 8) begin
					r = $urandom;
					l = $urandom;
					h = $urandom;
				end
				send_tick(r[31:0], l[31:0], h[31:0]);
			end
			done += n;
		end
	endtask

	initial begin
		ledger = new();
		cur    = default_cfg();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 6;
		recv_gap_pct = 62;

		// power-on settings, forward with zero setpoint
		load_config(cur);
		send_tick(0, 0, 0);
		send_tick(WORD_MAX, WORD_MAX, 0);
		send_tick(WORD_MIN, WORD_MIN, WORD_MAX);
		send_tick(WORD_MAX, WORD_MIN, WORD_MIN);
		send_tick(-1, 0, 0);
		send_tick(1, 0, 0);
		send_tick(-1, -1, -1);

		// reverse at the most negative setpoint: full negative drive flips to
		// the positive limit, error_now clips low, negative error brakes
		cur.mode   = MODE_REV;
		cur.target = WORD_MIN;
		load_config(cur);
		send_tick(WORD_MIN, WORD_MIN, 0);
		send_tick(WORD_MAX, WORD_MAX, 0);
		send_tick(0, 0, 0);

		// left turn with a zero ceiling, heading at both ends
		cur.mode          = MODE_LEFT;
		cur.drive_ceiling = '0;
		load_config(cur);
		send_tick(0, 0, WORD_MIN);
		send_tick(0, 0, 0);
		send_tick(0, 0, WORD_MAX);

		// right turn, gains and limits at their tops, speed limit zero
		cur.mode          = MODE_RIGHT;
		cur.target        = '0;
		cur.gain_p        = '1;
		cur.gain_i        = '1;
		cur.gain_d        = '1;
		cur.error_limit   = '1;
		cur.speed_limit   = '0;
		cur.drive_ceiling = '1;
		load_config(cur);
		send_tick(0, 0, WORD_MAX);
		send_tick(0, 0, 0);

		// back to forward with zero gains, its state carried over
		cur.mode        = MODE_FWD;
		cur.target      = 1234;
		cur.gain_p      = '0;
		cur.gain_i      = '0;
		cur.gain_d      = '0;
		cur.error_limit = '0;
		cur.speed_limit = '1;
		load_config(cur);
		send_tick(0, 0, 0);
		send_tick(WORD_MAX, WORD_MAX, 0);

		// reverse again after a brake, ticks keep being processed
		cur        = default_cfg();
		cur.mode   = MODE_REV;
		cur.target = 100;
		load_config(cur);
		send_tick(0, 0, 0);
		send_tick(0, 0, 0);

		random_moves(500);

		send_gap_pct = 62;
		recv_gap_pct = 6;
		random_moves(500);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		random_moves(500);

		drain();
		if (ledger.mismatches == 0 && ledger.pending_cmds.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/dps_pkg.sv
src/dps_ram.sv
src/dps_err.sv
src/dps_core.sv
src/drive_pid_step.sv
tb/drive_cmd_pkg.sv
tb/drive_pid_step_test.sv
